>>> rtl/iovsg_pkg.sv
// Shared types and constants of the IO vector to scatter-gather list builder.
`default_nettype none

package iovsg_pkg;

    localparam int ADDR_WIDTH_DEF = 64;

    localparam int OFFSET_W = 64;
    localparam int LEN_W    = 32;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 2;

    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_EMIT   = 2'd1;
    localparam logic [1:0] PH_CLOSED = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 2'd2;

    localparam logic [INDEX_W-1:0] REG_START_OFFSET    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_TRANSFER_LENGTH = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MAX_ENTRIES     = 2'd2;

    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = 8'd4;

    typedef struct packed {
        logic [OFFSET_W-1:0] start_offset;
        logic [LEN_W-1:0]    transfer_length;
        logic [COUNT_W-1:0]  max_entries;
    } cfg_t;

    typedef struct packed {
        logic                entry_valid;
        logic [LEN_W-1:0]    sge_length;
        logic [KEY_W-1:0]    sge_key;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
        logic                list_done;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/iovec_to_scatter_gather.sv
// Top level of the IO vector to scatter-gather list builder.
// A result passes the input register and then the result register.
// Throughput: one IO vector entry per cycle; the input stalls only while the result is not taken.
// Each entry passes an input register, then one pass of skip and clip logic.
// Reset clears the list state and both valid flags, and sets max_entries to 4.
`default_nettype none

module iovec_to_scatter_gather
    import iovsg_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [INDEX_W-1:0]    cfg_index,
    input  wire logic [OFFSET_W-1:0]   cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [ADDR_WIDTH-1:0] base_address,
    input  wire logic [LEN_W-1:0]      entry_length,
    input  wire logic [KEY_W-1:0]      memory_key,
    input  wire logic                  last_entry,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       entry_valid,
    output logic [ADDR_WIDTH-1:0]      sge_address,
    output logic [LEN_W-1:0]           sge_length,
    output logic [KEY_W-1:0]           sge_key,
    output logic [COUNT_W-1:0]         entry_count,
    output logic [STATUS_W-1:0]        status,
    output logic                       list_done
);

    cfg_t                  cfg;
    logic                  in_valid_reg;
    logic [ADDR_WIDTH-1:0] base_reg;
    logic [LEN_W-1:0]      length_reg;
    logic [KEY_W-1:0]      key_reg;
    logic                  last_reg;
    logic                  advance;
    logic                  fire;
    logic                  res_valid;
    result_t               res;
    logic [ADDR_WIDTH-1:0] res_address;
    result_t               out_res;

    assign in_ready = !in_valid_reg || advance;
    assign fire = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            base_reg <= base_address;
            length_reg <= entry_length;
            key_reg <= memory_key;
            last_reg <= last_entry;
        end
    end

    iovsg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iovsg_engine #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .fire         (fire),
        .base_address (base_reg),
        .entry_length (length_reg),
        .memory_key   (key_reg),
        .last_entry   (last_reg),
        .res_valid    (res_valid),
        .res          (res),
        .res_address  (res_address)
    );

    iovsg_out #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res         (res),
        .res_address (res_address),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_res     (out_res),
        .out_address (sge_address)
    );

    assign entry_valid = out_res.entry_valid;
    assign sge_length = out_res.sge_length;
    assign sge_key = out_res.sge_key;
    assign entry_count = out_res.entry_count;
    assign status = out_res.status;
    assign list_done = out_res.list_done;

endmodule

`default_nettype wire

>>> rtl/iovsg_cfg.sv
// Configuration register file of the scatter-gather list builder.
`default_nettype none

module iovsg_cfg
    import iovsg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [INDEX_W-1:0]  cfg_index,
    input  wire logic [OFFSET_W-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_offset    <= '0;
            cfg_reg.transfer_length <= '0;
            cfg_reg.max_entries     <= MAX_ENTRIES_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_OFFSET:    cfg_reg.start_offset    <= cfg_data;
                REG_TRANSFER_LENGTH: cfg_reg.transfer_length <= cfg_data[LEN_W-1:0];
                REG_MAX_ENTRIES:     cfg_reg.max_entries     <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/iovsg_engine.sv
// List state and the per-entry skip, clip and close logic.
`default_nettype none

module iovsg_engine
    import iovsg_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire logic                  fire,
    input  wire logic [ADDR_WIDTH-1:0] base_address,
    input  wire logic [LEN_W-1:0]      entry_length,
    input  wire logic [KEY_W-1:0]      memory_key,
    input  wire logic                  last_entry,
    output logic                       res_valid,
    output result_t                    res,
    output logic [ADDR_WIDTH-1:0]      res_address
);

    logic [OFFSET_W-1:0] skipped_reg;
    logic [OFFSET_W-1:0] skipped_next;
    logic [LEN_W-1:0]    covered_reg;
    logic [LEN_W-1:0]    covered_next;
    logic [COUNT_W-1:0]  emitted_reg;
    logic [COUNT_W-1:0]  emitted_next;
    logic [1:0]          phase_reg;
    logic [1:0]          phase_next;

    logic [OFFSET_W-1:0] remain;
    logic [LEN_W-1:0]    in_offset;
    logic [LEN_W-1:0]    avail;
    logic [LEN_W-1:0]    need;
    logic [LEN_W-1:0]    clipped;
    logic                use_entry;
    logic                emitting;
    logic                take;
    logic                done;
    logic [STATUS_W-1:0] status;

    always_comb
    begin
        remain = (cfg.start_offset > skipped_reg) ? cfg.start_offset - skipped_reg : '0;
        skipped_next = skipped_reg;
        covered_next = covered_reg;
        emitted_next = emitted_reg;
        phase_next = phase_reg;
        in_offset = '0;
        use_entry = 1'b1;
        emitting = 1'b0;
        take = 1'b0;
        done = 1'b0;
        status = ST_OK;

        unique case (phase_reg)
            PH_SKIP:
            begin
                if (remain == '0)
                begin
                    emitting = 1'b1;
                end
                else if (remain < OFFSET_W'(entry_length))
                begin
                    skipped_next = cfg.start_offset;
                    in_offset = remain[LEN_W-1:0];
                    emitting = 1'b1;
                end
                else
                begin
                    skipped_next = skipped_reg + OFFSET_W'(entry_length);
                    emitting = (remain == OFFSET_W'(entry_length));
                    use_entry = 1'b0;
                end
            end
            PH_EMIT:
            begin
                emitting = 1'b1;
            end
            default:
            begin
            end
        endcase

        avail = entry_length - in_offset;
        need = cfg.transfer_length - covered_reg;
        clipped = (avail > need) ? need : avail;

        if (emitting)
        begin
            phase_next = PH_EMIT;
            if (covered_reg >= cfg.transfer_length)
            begin
                done = 1'b1;
            end
            else if (use_entry && avail != '0)
            begin
                if (emitted_reg >= cfg.max_entries)
                begin
                    done = 1'b1;
                    status = ST_TOO_MANY;
                end
                else
                begin
                    take = 1'b1;
                    covered_next = covered_reg + clipped;
                    emitted_next = emitted_reg + 1'b1;
                    done = (avail >= need);
                end
            end
        end

        if (phase_reg != PH_CLOSED && !done && last_entry)
        begin
            done = 1'b1;
            status = ST_TOO_SHORT;
        end

        res_valid = fire && phase_reg != PH_CLOSED && (done || take);
        res.entry_valid = take;
        res.sge_length = take ? clipped : '0;
        res.sge_key = take ? memory_key : '0;
        res.entry_count = emitted_next;
        res.status = status;
        res.list_done = done;
        res_address = take ? base_address + ADDR_WIDTH'(in_offset) : '0;

        if (last_entry)
        begin
            skipped_next = '0;
            covered_next = '0;
            emitted_next = '0;
            phase_next = PH_SKIP;
        end
        else if (done)
        begin
            phase_next = PH_CLOSED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skipped_reg <= '0;
            covered_reg <= '0;
            emitted_reg <= '0;
            phase_reg <= PH_SKIP;
        end
        else if (fire)
        begin
            skipped_reg <= skipped_next;
            covered_reg <= covered_next;
            emitted_reg <= emitted_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/iovsg_out.sv
// Result register that holds one scatter-gather result until it is taken.
`default_nettype none

module iovsg_out
    import iovsg_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  res_valid,
    input  wire result_t               res,
    input  wire logic [ADDR_WIDTH-1:0] res_address,
    output logic                       advance,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output result_t                    out_res,
    output logic [ADDR_WIDTH-1:0]      out_address
);

    logic                  out_valid_reg;
    result_t               res_reg;
    logic [ADDR_WIDTH-1:0] address_reg;

    assign advance = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res = res_reg;
    assign out_address = address_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
            address_reg <= res_address;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench of the IO vector to scatter-gather list builder.
`timescale 1ns / 1ps

module tb;
    import iovsg_pkg::*;

    localparam int ADDR_W = ADDR_WIDTH_DEF;
    localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 140;

    typedef struct {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [KEY_W-1:0]  key;
        logic              is_last;
    } iov_entry_t;

    typedef struct {
        logic                entry_valid;
        logic [ADDR_W-1:0]   address;
        logic [LEN_W-1:0]    length;
        logic [KEY_W-1:0]    key;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic                list_done;
    } sge_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [OFFSET_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [ADDR_W-1:0] base_address = '0;
    logic [LEN_W-1:0] entry_length = '0;
    logic [KEY_W-1:0] memory_key = '0;
    logic last_entry = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic entry_valid;
    logic [ADDR_W-1:0] sge_address;
    logic [LEN_W-1:0] sge_length;
    logic [KEY_W-1:0] sge_key;
    logic [COUNT_W-1:0] entry_count;
    logic [STATUS_W-1:0] status;
    logic list_done;

    iov_entry_t pending_iov[$];
    iov_entry_t held_iov;
    sge_t sge_expected[$];
    sge_t want_sge;

    logic [OFFSET_W-1:0] start_offset_reg;
    logic [LEN_W-1:0] transfer_length_reg;
    logic [COUNT_W-1:0] max_entries_reg;

    logic [OFFSET_W-1:0] skipped_bytes;
    logic [LEN_W-1:0] covered_bytes;
    logic [COUNT_W-1:0] emitted_count;
    logic [1:0] list_phase;

    int errors = 0;
    int cycles = 0;
    int iov_accepted = 0;
    int sge_emitted = 0;
    int lists_ok = 0;
    int lists_too_many = 0;
    int lists_too_short = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;
    bit quiet = 1'b0;
    int pushed;

    iovec_to_scatter_gather dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_address (base_address),
        .entry_length (entry_length),
        .memory_key   (memory_key),
        .last_entry   (last_entry),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .entry_valid  (entry_valid),
        .sge_address  (sge_address),
        .sge_length   (sge_length),
        .sge_key      (sge_key),
        .entry_count  (entry_count),
        .status       (status),
        .list_done    (list_done)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    task automatic clear_list_state();
        skipped_bytes = '0;
        covered_bytes = '0;
        emitted_count = '0;
        list_phase = PH_SKIP;
    endtask

    // Works out the scatter-gather result, if any, that one IO vector entry causes.
    task automatic build_sge(input iov_entry_t e);
        logic [OFFSET_W-1:0] rem;
        logic [LEN_W-1:0] inoff;
        logic [LEN_W-1:0] avail;
        logic [LEN_W-1:0] need;
        logic take;
        logic done;
        sge_t r;
        rem = '0;
        inoff = '0;
        take = 1'b1;
        done = 1'b0;
        r = '{default: '0};
        r.status = ST_OK;
        if (list_phase == PH_CLOSED)
        begin
            if (e.is_last)
                clear_list_state();
            return;
        end
        if (list_phase == PH_SKIP)
        begin
            rem = (start_offset_reg > skipped_bytes) ? start_offset_reg - skipped_bytes : '0;
            if (rem == 0)
            begin
                list_phase = PH_EMIT;
            end
            else if (rem < {32'd0, e.len})
            begin
                skipped_bytes = start_offset_reg;
                inoff = rem[LEN_W-1:0];
                list_phase = PH_EMIT;
            end
            else
            begin
                skipped_bytes = skipped_bytes + {32'd0, e.len};
                if (rem == {32'd0, e.len})
                    list_phase = PH_EMIT;
                take = 1'b0;
            end
        end
        if (list_phase == PH_EMIT)
        begin
            if (covered_bytes >= transfer_length_reg)
            begin
                done = 1'b1;
                r.status = ST_OK;
            end
            else if (take)
            begin
                avail = e.len - inoff;
                if (avail != 0)
                begin
                    need = transfer_length_reg - covered_bytes;
                    if (avail > need)
                        avail = need;
                    if (emitted_count >= max_entries_reg)
                    begin
                        done = 1'b1;
                        r.status = ST_TOO_MANY;
                    end
                    else
                    begin
                        r.entry_valid = 1'b1;
                        r.address = e.base + {{(ADDR_W-LEN_W){1'b0}}, inoff};
                        r.length = avail;
                        r.key = e.key;
                        covered_bytes = covered_bytes + avail;
                        emitted_count = emitted_count + 1'b1;
                        if (covered_bytes >= transfer_length_reg)
                        begin
                            done = 1'b1;
                            r.status = ST_OK;
                        end
                    end
                end
            end
        end
        if (!done && e.is_last)
        begin
            done = 1'b1;
            r.status = ST_TOO_SHORT;
        end
        if (!done && !r.entry_valid)
            return;
        r.count = emitted_count;
        r.list_done = done;
        sge_expected.push_back(r);
        if (e.is_last)
            clear_list_state();
        else if (done)
            list_phase = PH_CLOSED;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Input side: one transfer per handshake, with random gaps between entries.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                build_sge(held_iov);
                iov_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_iov.size() > 0)
                begin
                    held_iov = pending_iov.pop_front();
                    in_valid <= 1'b1;
                    base_address <= held_iov.base;
                    entry_length <= held_iov.len;
                    memory_key <= held_iov.key;
                    last_entry <= held_iov.is_last;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 10);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 150;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (sge_expected.size() == 0)
            begin
                $error("unexpected result transfer: entry_valid %0b list_done %0b status %0d",
                       entry_valid, list_done, status);
                errors++;
            end
            else
            begin
                want_sge = sge_expected.pop_front();
                check_field("entry_valid", want_sge.entry_valid, entry_valid);
                check_field("sge_address", want_sge.address, sge_address);
                check_field("sge_length", want_sge.length, sge_length);
                check_field("sge_key", want_sge.key, sge_key);
                check_field("entry_count", want_sge.count, entry_count);
                check_field("status", want_sge.status, status);
                check_field("list_done", want_sge.list_done, list_done);
                if (want_sge.entry_valid)
                    sge_emitted++;
                if (want_sge.list_done)
                begin
                    if (want_sge.status == ST_OK)
                        lists_ok++;
                    else if (want_sge.status == ST_TOO_MANY)
                        lists_too_many++;
                    else
                        lists_too_short++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [OFFSET_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_START_OFFSET:    start_offset_reg = val;
            REG_TRANSFER_LENGTH: transfer_length_reg = val[LEN_W-1:0];
            REG_MAX_ENTRIES:     max_entries_reg = val[COUNT_W-1:0];
            default:             ;
        endcase
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Lets the block run dry: all entries sent, all results back, pipeline empty.
    task automatic settle();
        do
            @(negedge clk);
        while (pending_iov.size() != 0 || in_valid || sge_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic add_iov(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len,
                           input logic is_last);
        iov_entry_t e;
        e.base = base;
        e.len = len;
        e.key = $urandom;
        e.is_last = is_last;
        pending_iov.push_back(e);
        pushed++;
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 19))
            0, 1:    return '0;
            2:       return $urandom;
            3:       return '1;
            default: return $urandom_range(1, 120);
        endcase
    endfunction

    task automatic add_vector();
        int n;
        int shape;
        n = $urandom_range(1, 8);
        shape = $urandom_range(0, 19);
        for (int i = 0; i < n; i++)
        begin
            if (shape < 2)
                add_iov({$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)));
            else if (shape < 4)
                add_iov({$urandom, $urandom}, pick_len(), 1'b0);
            else
                add_iov({$urandom, $urandom}, pick_len(), i == n - 1);
        end
    endtask

    task automatic random_config(input bit every);
        logic [OFFSET_W-1:0] v;
        if (every || $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = {$urandom, $urandom};
                2:       v = '1;
                default: v = OFFSET_W'($urandom_range(0, 160));
            endcase
            write_reg(REG_START_OFFSET, v);
        end
        if (every || $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = {32'd0, $urandom};
                2:       v = {32'd0, 32'hFFFF_FFFF};
                default: v = OFFSET_W'($urandom_range(1, 300));
            endcase
            write_reg(REG_TRANSFER_LENGTH, v);
        end
        if (every || $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 9))
                0:       v = 64'd255;
                1:       v = 64'd1;
                default: v = OFFSET_W'($urandom_range(1, 8));
            endcase
            write_reg(REG_MAX_ENTRIES, v);
        end
    endtask

    initial
    begin
        start_offset_reg = '0;
        transfer_length_reg = '0;
        max_entries_reg = MAX_ENTRIES_RST;
        clear_list_state();
        pushed = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);

        write_reg(REG_UNUSED, {$urandom, $urandom});

        // Zero transfer length closes the list at once; the trailing last entry is absorbed.
        add_iov('0, 32'd7, 1'b0);
        add_iov({$urandom, $urandom}, 32'd9, 1'b1);
        settle();

        // Offset ends on an entry boundary, an empty entry, then the entry limit.
        write_reg(REG_START_OFFSET, 64'd10);
        write_reg(REG_TRANSFER_LENGTH, 64'd100);
        write_reg(REG_MAX_ENTRIES, 64'd2);
        add_iov({$urandom, $urandom}, 32'd4, 1'b0);
        add_iov({$urandom, $urandom}, 32'd6, 1'b0);
        add_iov({$urandom, $urandom}, 32'd0, 1'b0);
        add_iov({$urandom, $urandom}, 32'd50, 1'b0);
        add_iov({$urandom, $urandom}, 32'd30, 1'b0);
        add_iov({$urandom, $urandom}, 32'd40, 1'b0);
        add_iov({$urandom, $urandom}, 32'd5, 1'b1);
        settle();

        // Offset lands inside an entry whose address wraps, then the last entry is clipped.
        write_reg(REG_START_OFFSET, 64'd5);
        write_reg(REG_TRANSFER_LENGTH, 64'd20);
        write_reg(REG_MAX_ENTRIES, 64'd255);
        add_iov('1, 32'd8, 1'b0);
        add_iov({$urandom, $urandom}, 32'd100, 1'b1);
        settle();

        // Vector too short, once during the skip and once with an entry on the closing step.
        add_iov({$urandom, $urandom}, 32'd3, 1'b1);
        add_iov({$urandom, $urandom}, 32'd10, 1'b0);
        add_iov({$urandom, $urandom}, 32'd2, 1'b1);
        settle();

        write_reg(REG_MAX_ENTRIES, 64'd0);
        add_iov({$urandom, $urandom}, 32'd10, 1'b1);
        settle();

        write_reg(REG_START_OFFSET, '1);
        write_reg(REG_TRANSFER_LENGTH, {32'd0, 32'hFFFF_FFFF});
        write_reg(REG_MAX_ENTRIES, 64'd1);
        add_iov({$urandom, $urandom}, 32'hFFFF_FFFF, 1'b0);
        add_iov({$urandom, $urandom}, 32'hFFFF_FFFF, 1'b1);
        settle();

        write_reg(REG_START_OFFSET, 64'd0);
        add_iov({$urandom, $urandom}, 32'hFFFF_FFFF, 1'b0);
        add_iov({$urandom, $urandom}, 32'd0, 1'b1);
        settle();

        // Registers rewritten in the middle of a list.
        write_reg(REG_TRANSFER_LENGTH, 64'd100);
        write_reg(REG_MAX_ENTRIES, 64'd4);
        add_iov({$urandom, $urandom}, 32'd50, 1'b0);
        settle();
        write_reg(REG_TRANSFER_LENGTH, 64'd40);
        add_iov({$urandom, $urandom}, 32'd7, 1'b0);
        add_iov({$urandom, $urandom}, 32'd1, 1'b1);
        settle();
        write_reg(REG_START_OFFSET, 64'd100);
        add_iov({$urandom, $urandom}, 32'd30, 1'b0);
        settle();
        write_reg(REG_START_OFFSET, 64'd20);
        add_iov({$urandom, $urandom}, 32'd10, 1'b0);
        add_iov({$urandom, $urandom}, 32'd3, 1'b1);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_config(ph == 0);
            pushed = 0;
            while (pushed < PHASE_ITEMS)
                add_vector();
            if (ph == 3)
                hold_request = 1'b1;
            settle();
        end

        quiet = 1'b1;
        random_config(1'b1);
        pushed = 0;
        while (pushed < 100)
            add_vector();
        settle();

        $display("Covered %0d IO vector entries and %0d scatter-gather entries,", iov_accepted,
                 sge_emitted);
        $display("with %0d lists ok, %0d over the entry limit and %0d short.", lists_ok,
                 lists_too_many, lists_too_short);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
